// File: hdl/ntdc_pkg.sv
// shared types, constants and the digit template table for the classifier
// no dependencies
package ntdc_pkg;

	localparam int NUM_CLASSES   = 10;
	localparam int MAX_FEATURES  = 13;
	localparam int TMPL_ROWS     = 10;
	localparam int TMPL_COLS     = 13;

	localparam int FEAT_W = 8;
	localparam int DIST_W = 16;
	localparam int CHAR_W = 7;
	localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int POS_W  = $clog2(MAX_FEATURES + 1);
	localparam int ROW_W  = $clog2(TMPL_ROWS);
	localparam int COL_W  = $clog2(TMPL_COLS);

	localparam logic [DIST_W-1:0] DIST_SAT      = 16'd65535;
	localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;
	localparam logic [CHAR_W-1:0] NO_MATCH_CHAR = 7'd110;

	typedef logic [FEAT_W-1:0] tmpl_row_t [TMPL_COLS];

	localparam tmpl_row_t TMPL [TMPL_ROWS] = '{
		'{8'd3,  8'd2,  8'd10, 8'd12, 8'd10, 8'd8,  8'd4,  8'd2,  8'd51, 8'd5, 8'd3, 8'd7, 8'd14},
		'{8'd8,  8'd9,  8'd12, 8'd11, 8'd8,  8'd12, 8'd6,  8'd11, 8'd70, 8'd7, 8'd5, 8'd8, 8'd8},
		'{8'd11, 8'd13, 8'd4,  8'd12, 8'd9,  8'd5,  8'd14, 8'd12, 8'd80, 8'd3, 8'd3, 8'd0, 8'd8},
		'{8'd10, 8'd13, 8'd6,  8'd12, 8'd6,  8'd10, 8'd10, 8'd11, 8'd78, 8'd3, 8'd3, 8'd8, 8'd8},
		'{8'd5,  8'd12, 8'd9,  8'd12, 8'd14, 8'd14, 8'd6,  8'd13, 8'd85, 8'd5, 8'd7, 8'd8, 8'd8},
		'{8'd9,  8'd4,  8'd14, 8'd11, 8'd7,  8'd8,  8'd9,  8'd12, 8'd74, 8'd7, 8'd3, 8'd8, 8'd8},
		'{8'd13, 8'd13, 8'd15, 8'd11, 8'd8,  8'd8,  8'd12, 8'd12, 8'd92, 8'd6, 8'd3, 8'd8, 8'd0},
		'{8'd8,  8'd14, 8'd3,  8'd10, 8'd7,  8'd4,  8'd8,  8'd0,  8'd54, 8'd4, 8'd2, 8'd8, 8'd8},
		'{8'd3,  8'd2,  8'd10, 8'd12, 8'd10, 8'd8,  8'd4,  8'd2,  8'd51, 8'd8, 8'd6, 8'd7, 8'd14},
		'{8'd11, 8'd9,  8'd12, 8'd12, 8'd8,  8'd12, 8'd7,  8'd7,  8'd78, 8'd5, 8'd3, 8'd7, 8'd14}
	};

	// word handed from cell to cell: one feature byte plus the running best
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              en;
		logic [POS_W-1:0]  pos;
		logic [FEAT_W-1:0] feature;
		logic [DIST_W-1:0] best_dist;
		logic [CHAR_W-1:0] best_char;
	} word_t;

	function automatic logic [FEAT_W-1:0] tmpl_at(input logic [CLS_W-1:0] cls,
			input logic [POS_W-1:0] pos);
		logic [FEAT_W-1:0] v;
		v = '0;
		if (32'(cls) < TMPL_ROWS && 32'(pos) < TMPL_COLS) begin
			v = TMPL[ROW_W'(cls)][COL_W'(pos)];
		end
		return v;
	endfunction

endpackage

// File: hdl/ntdc_cell.sv
// one class cell: squared difference, saturating accumulation, best-so-far update
// depends on ntdc_pkg
module ntdc_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [ntdc_pkg::CLS_W-1:0] class_idx,
	input  ntdc_pkg::word_t            word_in,
	output ntdc_pkg::word_t            word_out
);

	ntdc_pkg::word_t                word_s1;
	logic [ntdc_pkg::DIST_W-1:0]    sq_s1;
	ntdc_pkg::word_t                word_s2;
	logic [ntdc_pkg::DIST_W-1:0]    acc_q;

	logic [ntdc_pkg::FEAT_W-1:0]    tmpl_v;
	logic [ntdc_pkg::FEAT_W-1:0]    diff;
	logic [ntdc_pkg::DIST_W:0]      sum;
	logic [ntdc_pkg::DIST_W-1:0]    acc_next;
	ntdc_pkg::word_t                word_nxt;

	always_comb begin
		tmpl_v = ntdc_pkg::tmpl_at(class_idx, word_in.pos);
		diff   = (word_in.feature >= tmpl_v) ? (word_in.feature - tmpl_v)
			: (tmpl_v - word_in.feature);
	end

	// stage one: square the difference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_s1 <= '0;
			sq_s1   <= '0;
		end else if (advance) begin
			word_s1 <= word_in;
			sq_s1 <= word_in.en ? (ntdc_pkg::DIST_W'(diff) * ntdc_pkg::DIST_W'(diff)) : '0;
		end
	end

	// stage two: accumulate with saturation and fold into the running best
	always_comb begin
		sum      = {1'b0, acc_q} + {1'b0, sq_s1};
		acc_next = sum[ntdc_pkg::DIST_W] ? ntdc_pkg::DIST_SAT : sum[ntdc_pkg::DIST_W-1:0];
		word_nxt = word_s1;
		if (word_s1.last && acc_next < word_s1.best_dist) begin
			word_nxt.best_dist = acc_next;
			word_nxt.best_char = ntdc_pkg::ASCII_ZERO + ntdc_pkg::CHAR_W'(class_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			word_s2 <= '0;
		end else if (advance) begin
			word_s2 <= word_nxt;
			if (word_s1.valid) begin
				acc_q <= word_s1.last ? '0 : acc_next;
			end
		end
	end

	assign word_out = word_s2;

endmodule

// File: hdl/nearest_template_digit_classifier_core.sv
// top level: position tracking, the chain of class cells and the result register
// depends on ntdc_pkg and ntdc_cell
//
// Usage:
//   Input channel: feature_value with last_feature, under in_valid / in_stall.
//   One feature byte is taken per cycle while in_stall is low; bytes past the
//   thirteenth of a vector add nothing, and last_feature closes the vector.
//   Output channel: result_char under out_valid / out_stall, one word per
//   vector: '0'..'9' for the nearest template, 'n' if every distance saturated.
//   Throughput: one input word per cycle while in_stall is low.
//   Path: a last feature is taken into the first cell's square register at the
//   accepting edge, then passes through each class cell in turn (square, then
//   accumulate and compare), and the result register loads once it leaves the
//   tenth cell.
//   Reset: clears all distances, the position count and every valid flag.
//   Stall: a waiting result sits in the output register while later words keep
//   moving; the chain only halts when a second result reaches its end while
//   the first is still held, and then in_stall rises.
module nearest_template_digit_classifier_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ntdc_pkg::FEAT_W-1:0]   feature_value,
	input  logic                          last_feature,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ntdc_pkg::CHAR_W-1:0]   result_char
);

	ntdc_pkg::word_t             chain [ntdc_pkg::NUM_CLASSES+1];
	logic [ntdc_pkg::POS_W-1:0]  pos_q;
	logic                        advance;
	logic                        accept;
	logic                        end_last;
	logic                        out_valid_q;
	logic [ntdc_pkg::CHAR_W-1:0] result_q;

	assign end_last = chain[ntdc_pkg::NUM_CLASSES].valid && chain[ntdc_pkg::NUM_CLASSES].last;
	assign advance  = !(out_valid_q && out_stall && end_last);
	assign in_stall = !advance;
	assign accept   = in_valid && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (last_feature) begin
				pos_q <= '0;
			end else if (32'(pos_q) < ntdc_pkg::MAX_FEATURES) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_comb begin
		chain[0].valid     = accept;
		chain[0].last      = last_feature;
		chain[0].en        = 32'(pos_q) < ntdc_pkg::MAX_FEATURES;
		chain[0].pos       = pos_q;
		chain[0].feature   = feature_value;
		chain[0].best_dist = ntdc_pkg::DIST_SAT;
		chain[0].best_char = ntdc_pkg::NO_MATCH_CHAR;
	end

	for (genvar i = 0; i < ntdc_pkg::NUM_CLASSES; i++) begin : g_cell
		ntdc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.class_idx (ntdc_pkg::CLS_W'(i)),
			.word_in   (chain[i]),
			.word_out  (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_last) begin
			result_q <= chain[ntdc_pkg::NUM_CLASSES].best_char;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_char = result_q;

endmodule
